### rtl/text_mode_terminal_writer_unit_macros.svh
// Assertion macros for the text mode terminal writer.
// Depends on nothing; included by the top level only.
`ifndef TEXT_MODE_TERMINAL_WRITER_UNIT_MACROS_SVH
`define TEXT_MODE_TERMINAL_WRITER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TMTW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TMTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tmtw_pkg.sv
// Shared constants, codes and the command word for the terminal writer.
// No dependencies.
package tmtw_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam int         TAB_STEP   = 4;
    localparam logic [7:0] RESET_ATTR = 8'd7;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_MOVE  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [1:0] FILL_NONE = 2'd0;
    localparam logic [1:0] FILL_ROW  = 2'd1;
    localparam logic [1:0] FILL_ALL  = 2'd2;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] wr_data;
        logic [1:0]        fill;
        logic [ADDR_W-1:0] fill_start;
        logic [COL_W-1:0]  cur_col;
        logic [ROW_W-1:0]  cur_row;
        logic [POS_W-1:0]  cur_pos;
        logic              scrolled;
    } t_cmd;

endpackage

### rtl/text_mode_terminal_writer_unit.sv
// For put, read and move the back end pops the word, then loads the output register once it is free;
// before that a scroll blanks one row (COLS cells) and a clear all COLS*ROWS (2000) cells in the back end.
// The back end takes a new word only once the last has reached the output register.
// Reset: synchronous active low; then a clearing pass writes every one of the 2000 cells
// to space/attr 7 with o_ready low. Config writes are taken throughout.
// Depends on tmtw_pkg, tmtw_front, tmtw_queue, tmtw_back and the macros header.
`include "text_mode_terminal_writer_unit_macros.svh"

module text_mode_terminal_writer_unit import tmtw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration: default blank attribute
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data,
    // request channel
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_req_type,
    input  logic [7:0]       i_char_code,
    input  logic [3:0]       i_fg_color,
    input  logic [3:0]       i_bg_color,
    input  logic [COL_W-1:0] i_cell_col,
    input  logic [ROW_W-1:0] i_cell_row,
    // result channel
    output logic             o_valid,
    input  logic             i_ready,
    output logic [COL_W-1:0] o_cursor_col,
    output logic [ROW_W-1:0] o_cursor_row,
    output logic [POS_W-1:0] o_cursor_pos,
    output logic [7:0]       o_cell_char,
    output logic [7:0]       o_cell_attr,
    output logic             o_scrolled
);

    // Blank-cell attribute used by clear and scroll fills; existing cells keep theirs.
    logic [7:0] r_default_attr;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    logic init_busy;
    t_cmd front_cmd;
    t_cmd q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_attr <= RESET_ATTR;
        end else if (i_cfg_we) begin
            r_default_attr <= i_cfg_data;
        end
    end

    // Front end: classify the word, advance the cursor, wrap and scroll,
    // and turn it into a store command. Scroll rotates a row base rather than
    // moving lines, so only the new bottom row needs blanking.
    tmtw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_char_code (i_char_code),
        .i_fg_color  (i_fg_color),
        .i_bg_color  (i_bg_color),
        .i_cell_col  (i_cell_col),
        .i_cell_row  (i_cell_row),
        .i_q_full    (q_full),
        .i_init_busy (init_busy),
        .o_push      (q_push),
        .o_cmd       (front_cmd)
    );

    // Hold commands so the front end keeps accepting while the back end fills.
    tmtw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Back end: carry out cell writes, reads and fills in order, then
    // drive the result from its output register.
    tmtw_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_default_attr (r_default_attr),
        .i_q_valid      (q_valid),
        .i_q_cmd        (q_cmd),
        .o_pop          (q_pop),
        .o_init_busy    (init_busy),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_cursor_col   (o_cursor_col),
        .o_cursor_row   (o_cursor_row),
        .o_cursor_pos   (o_cursor_pos),
        .o_cell_char    (o_cell_char),
        .o_cell_attr    (o_cell_attr),
        .o_scrolled     (o_scrolled)
    );

    // No word may enter while the store is still being cleared after reset.
    `TMTW_ASSERT_NOW(a_no_accept_in_init, i_clk, i_rst_n, init_busy, !o_ready, "accept during init clear")
    // The queue must never be pushed while full.
    `TMTW_ASSERT_NOW(a_queue_no_overflow, i_clk, i_rst_n, q_push, !q_full, "queue overflow")
    // Reported cursor always lands inside the screen.
    `TMTW_ASSERT_NOW(a_cursor_in_range, i_clk, i_rst_n, o_valid, (o_cursor_col < COL_W'(COLS)) && (o_cursor_row < ROW_W'(ROWS)), "cursor out of range")
    // A scrolling put never carries read data.
    `TMTW_ASSERT_NOW(a_scroll_no_read, i_clk, i_rst_n, o_valid && o_scrolled, (o_cell_char == 8'd0) && (o_cell_attr == 8'd0), "read data on scroll")
    // After a pop the back end leaves the idle state, so it never pops twice in a row.
    `TMTW_ASSERT_NEXT(a_pop_then_busy, i_clk, i_rst_n, q_pop, !q_pop, "back end popped twice in a row")

endmodule

### rtl/tmtw_front.sv
// Front end: accepts requests, tracks the cursor and row base, emits commands.
// Depends on tmtw_pkg.
module tmtw_front import tmtw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_req_type,
    input  logic [7:0]       i_char_code,
    input  logic [3:0]       i_fg_color,
    input  logic [3:0]       i_bg_color,
    input  logic [COL_W-1:0] i_cell_col,
    input  logic [ROW_W-1:0] i_cell_row,
    input  logic             i_q_full,
    input  logic             i_init_busy,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_line, n_line;
    logic [ROW_W-1:0] r_base, n_base;
    logic [COL_W:0]   n_col_w;
    logic [ROW_W:0]   n_line_w;
    logic             scroll;
    t_cmd             cmd;

    // Logical row to physical row through the circular row base.
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                  input logic [ROW_W-1:0] base);
        logic [ROW_W:0] sum;
        sum = {1'b0, lrow} + {1'b0, base};
        if (sum >= (ROW_W+1)'(ROWS)) begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(32'(prow) * COLS + 32'(col));
    endfunction

    assign o_ready = !i_q_full && !i_init_busy;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        cmd      = '0;
        n_col_w  = {1'b0, r_col};
        n_line_w = {1'b0, r_line};
        n_base   = r_base;
        scroll   = 1'b0;
        case (i_req_type)
            REQ_PUT: begin
                if (i_char_code == CH_TAB) begin
                    n_col_w = n_col_w + (COL_W+1)'(TAB_STEP);
                end else if (i_char_code == CH_NEWLINE) begin
                    n_line_w = n_line_w + 1'b1;
                    n_col_w  = '0;
                end else begin
                    cmd.wr_en   = 1'b1;
                    cmd.addr    = cell_addr(phys_row(r_line, r_base), r_col);
                    cmd.wr_data = {i_bg_color, i_fg_color, i_char_code};
                    n_col_w     = n_col_w + 1'b1;
                end
                if (n_col_w >= (COL_W+1)'(COLS)) begin
                    n_col_w  = '0;
                    n_line_w = n_line_w + 1'b1;
                end
                // Scroll: old top row becomes the blank bottom row.
                if (n_line_w >= (ROW_W+1)'(ROWS)) begin
                    scroll         = 1'b1;
                    n_line_w       = (ROW_W+1)'(ROWS - 1);
                    n_col_w        = '0;
                    cmd.fill       = FILL_ROW;
                    cmd.fill_start = cell_addr(r_base, COL_W'(0));
                    n_base = (r_base == ROW_W'(ROWS - 1)) ? '0 : r_base + 1'b1;
                end
            end
            REQ_READ: begin
                if (i_cell_col < COL_W'(COLS) && i_cell_row < ROW_W'(ROWS)) begin
                    cmd.rd_en = 1'b1;
                    cmd.addr  = cell_addr(phys_row(i_cell_row, r_base), i_cell_col);
                end
            end
            REQ_MOVE: begin
                n_col_w  = {1'b0, (i_cell_col < COL_W'(COLS)) ? i_cell_col
                                                               : COL_W'(COLS - 1)};
                n_line_w = {1'b0, (i_cell_row < ROW_W'(ROWS)) ? i_cell_row
                                                               : ROW_W'(ROWS - 1)};
            end
            REQ_CLEAR: begin
                cmd.fill       = FILL_ALL;
                cmd.fill_start = '0;
                n_col_w        = '0;
                n_line_w       = '0;
                n_base         = '0;
            end
            default: begin
            end
        endcase
        n_col        = n_col_w[COL_W-1:0];
        n_line       = n_line_w[ROW_W-1:0];
        cmd.cur_col  = n_col;
        cmd.cur_row  = n_line;
        cmd.cur_pos  = POS_W'(32'(n_line) * COLS + 32'(n_col));
        cmd.scrolled = scroll;
    end

    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_line <= '0;
            r_base <= '0;
        end else if (o_push) begin
            r_col  <= n_col;
            r_line <= n_line;
            r_base <= n_base;
        end
    end

endmodule

### rtl/tmtw_queue.sv
// Short command queue between the front end and the back end.
// Depends on tmtw_pkg.
module tmtw_queue import tmtw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/tmtw_back.sv
// Back end: cell store, write/read/fill sequencer and the output register.
// Depends on tmtw_pkg.
module tmtw_back import tmtw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_default_attr,
    input  logic             i_q_valid,
    input  t_cmd             i_q_cmd,
    output logic             o_pop,
    output logic             o_init_busy,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [COL_W-1:0] o_cursor_col,
    output logic [ROW_W-1:0] o_cursor_row,
    output logic [POS_W-1:0] o_cursor_pos,
    output logic [7:0]       o_cell_char,
    output logic [7:0]       o_cell_attr,
    output logic             o_scrolled
);

    localparam logic [1:0] ST_INIT = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rd_data;
    logic [1:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_fill_addr, n_fill_addr;
    logic [ADDR_W-1:0] r_fill_left, n_fill_left;
    t_cmd              r_cmd;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic              out_load;

    logic              r_out_valid;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [POS_W-1:0]  r_out_pos;
    logic [7:0]        r_out_char;
    logic [7:0]        r_out_attr;
    logic              r_out_scrolled;

    assign o_pop       = (r_state == ST_IDLE) && i_q_valid;
    assign o_init_busy = (r_state == ST_INIT);
    assign out_load    = (r_state == ST_DONE) && (!r_out_valid || i_ready);
    assign mem_re      = o_pop && i_q_cmd.rd_en;

    always_comb begin
        mem_we      = 1'b0;
        mem_waddr   = r_fill_addr;
        mem_wdata   = {i_default_attr, CH_SPACE};
        n_state     = r_state;
        n_fill_addr = r_fill_addr;
        n_fill_left = r_fill_left;
        case (r_state)
            ST_INIT: begin
                mem_we      = 1'b1;
                mem_wdata   = {RESET_ATTR, CH_SPACE};
                n_fill_addr = r_fill_addr + 1'b1;
                n_fill_left = r_fill_left - 1'b1;
                if (r_fill_left == '0) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (o_pop) begin
                    mem_we    = i_q_cmd.wr_en;
                    mem_waddr = i_q_cmd.addr;
                    mem_wdata = i_q_cmd.wr_data;
                    n_state   = ST_DONE;
                    if (i_q_cmd.fill != FILL_NONE) begin
                        n_state     = ST_FILL;
                        n_fill_addr = i_q_cmd.fill_start;
                        n_fill_left = (i_q_cmd.fill == FILL_ROW) ? ADDR_W'(COLS - 1)
                                                                 : ADDR_W'(CELLS - 1);
                    end
                end
            end
            ST_FILL: begin
                mem_we      = 1'b1;
                n_fill_addr = r_fill_addr + 1'b1;
                n_fill_left = r_fill_left - 1'b1;
                if (r_fill_left == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[i_q_cmd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (out_load) begin
            r_out_col      <= r_cmd.cur_col;
            r_out_row      <= r_cmd.cur_row;
            r_out_pos      <= r_cmd.cur_pos;
            r_out_char     <= r_cmd.rd_en ? r_rd_data[7:0] : 8'd0;
            r_out_attr     <= r_cmd.rd_en ? r_rd_data[15:8] : 8'd0;
            r_out_scrolled <= r_cmd.scrolled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_fill_addr <= '0;
            r_fill_left <= ADDR_W'(CELLS - 1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill_addr <= n_fill_addr;
            r_fill_left <= n_fill_left;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_cursor_pos = r_out_pos;
    assign o_cell_char  = r_out_char;
    assign o_cell_attr  = r_out_attr;
    assign o_scrolled   = r_out_scrolled;

endmodule
